// ===== design/nca_pkg.sv =====
// shared constants and types for the nearest centroid assignment core
`default_nettype none

package nca_pkg;

  // default sizes of the core
  localparam int unsigned MAX_CLUSTERS_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF     = 16;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // item field widths
  localparam int unsigned CLUSTER_W = 4;
  localparam int unsigned DIM_W     = 4;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned ASSIGN_W  = 5;
  localparam int unsigned DIST_W    = 37;

  // stream payload widths, tdata in whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 48;

  // field positions in the input tdata
  localparam int unsigned CLUSTER_LSB = 0;
  localparam int unsigned DIM_LSB     = CLUSTER_LSB + CLUSTER_W;
  localparam int unsigned VALUE_LSB   = DIM_LSB + DIM_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CLUSTERS = 1'b0,
    REG_NUM_DIMS     = 1'b1
  } cfg_reg_e;

  typedef enum logic [IN_TUSER_W-1:0] {
    ACT_LOAD  = 1'b0,
    ACT_POINT = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

`default_nettype wire

// ===== design/nearest_centroid_assign_core.sv =====
// nearest centroid assignment core: k-means assignment step over a centroid memory
`default_nettype none

// nearest centroid assignment (k-means assignment step)
// items arrive on the slave stream; tuser selects the kind: a load item writes one
// coordinate of one centroid into the centroid memory, a point item
// brings one coordinate of a point. for each active cluster k the core reads centroid
// coordinate (k, dim) and the running distance of k from two synchronous memories, then
// runs a shared subtract, square and saturating-add unit and writes the sum back.
// dimension 0 restarts the sums, other dimensions add to them. the point item with
// dim_index == num_dims-1 produces one result: the 1-based index of the nearest centroid
// (lowest index on a tie) and its squared distance, saturated at 2^37-1.
// a point coordinate issues one cluster per cycle through the single read port of the
// centroid memory followed by a three-stage pipeline. a point beyond num_dims is dropped.
// the input stays open while a result waits in the output register; only the next
// result to be produced waits for it to drain. num_clusters and num_dims of 0 act as 1,
// values above the maximum act as the maximum. reading a centroid coordinate never
// loaded gives an undefined distance.
module nearest_centroid_assign_core #(
  parameter int unsigned MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned MAX_DIMS     = nca_pkg::MAX_DIMS_DEF,
  parameter int unsigned COORD_BITS   = nca_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [nca_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [nca_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input items
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [nca_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // cluster_index, dim_index, value
  input  wire logic [nca_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,  // action
  // result items
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [nca_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o   // assigned_cluster, best_distance, pad
);
  import nca_pkg::*;

  localparam int unsigned KW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned AW    = $clog2(MAX_CLUSTERS * MAX_DIMS);
  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int unsigned NCW0  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned NCW   = (NCW0 > CFG_DATA_W) ? NCW0 : CFG_DATA_W;
  localparam int unsigned NDW0  = $clog2(MAX_DIMS + 1);
  localparam int unsigned NDW   = (NDW0 > CFG_DATA_W) ? NDW0 : CFG_DATA_W;
  localparam int unsigned EXTW  = (COORD_BITS > VALUE_W) ? COORD_BITS : VALUE_W;
  localparam int unsigned DIFFW = COORD_BITS + 1;
  localparam int unsigned SQW   = 2 * DIFFW;
  localparam int unsigned SUMW  = ((SQW > DIST_W) ? SQW : DIST_W) + 1;

  // configuration registers
  logic [CFG_DATA_W-1:0] num_clusters_q, num_dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= CFG_DATA_W'(1);
      num_dims_q     <= CFG_DATA_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_CLUSTERS: num_clusters_q <= cfg_wdata_i;
        REG_NUM_DIMS:     num_dims_q     <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // clamped counts
  logic [NCW-1:0] nc_w;
  logic [NDW-1:0] nd_w;
  logic [KW-1:0]  last_k;

  always_comb begin
    if (num_clusters_q == '0) begin
      nc_w = NCW'(1);
    end else if (NCW'(num_clusters_q) > NCW'(MAX_CLUSTERS)) begin
      nc_w = NCW'(MAX_CLUSTERS);
    end else begin
      nc_w = NCW'(num_clusters_q);
    end
    if (num_dims_q == '0) begin
      nd_w = NDW'(1);
    end else if (NDW'(num_dims_q) > NDW'(MAX_DIMS)) begin
      nd_w = NDW'(MAX_DIMS);
    end else begin
      nd_w = NDW'(num_dims_q);
    end
    last_k = KW'(nc_w - NCW'(1));
  end

  // input item fields
  logic [CLUSTER_W-1:0]   in_cluster;
  logic [DIM_W-1:0]       in_dim;
  logic [VALUE_W-1:0]     in_value;
  logic [EXTW-1:0]        in_value_ext;
  logic signed [COORD_BITS-1:0] in_coord;
  action_e                in_action;
  logic                   s_fire;

  assign in_cluster   = s_axis_tdata_i[CLUSTER_LSB +: CLUSTER_W];
  assign in_dim       = s_axis_tdata_i[DIM_LSB +: DIM_W];
  assign in_value     = s_axis_tdata_i[VALUE_LSB +: VALUE_W];
  assign in_value_ext = EXTW'(in_value);
  assign in_coord     = $signed(in_value_ext[COORD_BITS-1:0]);
  assign in_action    = action_e'(s_axis_tuser_i);

  // control
  state_e state_q, state_d;
  logic   s_ready;
  logic   load_fire, point_fire;
  logic   iss_q, iss_d;
  logic [KW-1:0] k_q, k_d;
  logic   final_q, restart_q;
  logic [DW-1:0] dim_q;
  logic signed [COORD_BITS-1:0] coord_q;

  assign s_ready         = (state_q == ST_IDLE);
  assign s_axis_tready_o = s_ready;
  assign s_fire          = s_axis_tvalid_i && s_ready;
  assign load_fire       = s_fire && (in_action == ACT_LOAD);
  assign point_fire      = s_fire && (in_action == ACT_POINT) && (NDW'(in_dim) < nd_w);

  // centroid memory, one write and one registered read port
  logic signed [COORD_BITS-1:0] cent_mem [DEPTH];
  logic signed [COORD_BITS-1:0] cent_rdata_q;
  logic          cent_we;
  logic [AW-1:0] cent_waddr, cent_raddr;

  assign cent_we    = load_fire && (in_cluster < MAX_CLUSTERS) && (in_dim < MAX_DIMS);
  assign cent_waddr = AW'(in_cluster * MAX_DIMS) + AW'(in_dim);
  assign cent_raddr = AW'(k_q * MAX_DIMS) + AW'(dim_q);

  always_ff @(posedge clk_i) begin
    if (cent_we) begin
      cent_mem[cent_waddr] <= in_coord;
    end
    cent_rdata_q <= cent_mem[cent_raddr];
  end

  // running distance memory, entries read as zero until first written
  logic [DIST_W-1:0] pd_mem [MAX_CLUSTERS];
  logic [DIST_W-1:0] pd_rdata_q;
  logic [MAX_CLUSTERS-1:0] pd_vld_q;
  logic              pd_we;
  logic [DIST_W-1:0] sum_sat;

  // pipeline: read, difference, square, accumulate
  logic              v_rd_q, v_df_q, v_sq_q;
  logic              l_rd_q, l_df_q, l_sq_q;
  logic [KW-1:0]     k_rd_q, k_df_q, k_sq_q;
  logic signed [DIFFW-1:0] diff_q;
  logic [DIST_W-1:0] base_df_q, base_sq_q;
  logic [SQW-1:0]    sq_q;
  logic signed [SQW-1:0] prod;
  logic [SUMW-1:0]   sum_raw;

  assign pd_we = v_sq_q;

  always_ff @(posedge clk_i) begin
    if (pd_we) begin
      pd_mem[k_sq_q] <= sum_sat;
    end
    pd_rdata_q <= pd_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_vld_q <= '0;
    end else if (pd_we) begin
      pd_vld_q[k_sq_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_rd_q <= 1'b0;
      v_df_q <= 1'b0;
      v_sq_q <= 1'b0;
    end else begin
      v_rd_q <= iss_q;
      v_df_q <= v_rd_q;
      v_sq_q <= v_df_q;
    end
  end

  assign prod = SQW'(diff_q) * SQW'(diff_q);

  always_ff @(posedge clk_i) begin
    l_rd_q    <= (k_q == last_k);
    k_rd_q    <= k_q;
    l_df_q    <= l_rd_q;
    k_df_q    <= k_rd_q;
    diff_q    <= DIFFW'(coord_q) - DIFFW'(cent_rdata_q);
    base_df_q <= (restart_q || !pd_vld_q[k_rd_q]) ? '0 : pd_rdata_q;
    l_sq_q    <= l_df_q;
    k_sq_q    <= k_df_q;
    sq_q      <= $unsigned(prod);
    base_sq_q <= base_df_q;
  end

  // saturating accumulate
  assign sum_raw = SUMW'(base_sq_q) + SUMW'(sq_q);
  assign sum_sat = (sum_raw > SUMW'(DIST_MAX)) ? DIST_MAX : sum_raw[DIST_W-1:0];

  // running minimum, strict compare keeps the lowest index on a tie
  logic [DIST_W-1:0] best_d_q, best_d_d;
  logic [KW-1:0]     best_k_q, best_k_d;

  always_comb begin
    best_d_d = best_d_q;
    best_k_d = best_k_q;
    if (v_sq_q) begin
      if ((k_sq_q == '0) || (sum_sat < best_d_q)) begin
        best_d_d = sum_sat;
        best_k_d = k_sq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_d_q <= best_d_d;
    best_k_q <= best_k_d;
  end

  // point coordinate latch
  always_ff @(posedge clk_i) begin
    if (point_fire) begin
      coord_q   <= in_coord;
      dim_q     <= DW'(in_dim);
      restart_q <= (in_dim == '0);
      final_q   <= (NDW'(in_dim) == (nd_w - NDW'(1)));
    end
  end

  // output register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   out_free, run_done, out_ld;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign run_done = v_sq_q && l_sq_q;
  assign out_ld   = out_free && (((state_q == ST_RUN) && run_done && final_q) ||
                                 (state_q == ST_WAIT));

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_ld) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_data_q <= OUT_TDATA_W'({best_d_d, ASSIGN_W'(best_k_d + KW'(1) == '0 ?
                  ASSIGN_W'(MAX_CLUSTERS) : ASSIGN_W'(best_k_d) + ASSIGN_W'(1))});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (point_fire) begin
          state_d = ST_RUN;
          iss_d   = 1'b1;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (iss_q) begin
          if (k_q == last_k) begin
            iss_d = 1'b0;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
        if (run_done) begin
          if (!final_q || out_free) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        iss_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      k_q     <= k_d;
    end
  end

  // checks
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(iss_q || v_rd_q || v_df_q || v_sq_q))
    else $error("input open while the distance pipeline is busy");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({v_rd_q && l_rd_q, v_df_q && l_df_q, v_sq_q && l_sq_q}) <= 1)
    else $error("more than one last cluster in flight");

  a_wait_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> m_valid_q)
    else $error("waiting for an empty output register");

  a_writeback_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_sq_q |-> (k_sq_q <= last_k))
    else $error("running distance written for an inactive cluster");

endmodule

`default_nettype wire
